// ----- rtl/gbr_pkg.sv -----
// shared types, constants and kernel weights for the 5x5 gaussian blur
`timescale 1ns / 1ps

package gbr_pkg;

    localparam int MaxWidth     = 1024;
    localparam int CoefFracBits = 16;
    localparam int ColW         = $clog2(MaxWidth);
    localparam int RowW         = 12;
    localparam int WidthW       = 11;
    localparam int PixW         = 24;
    localparam int NumClass     = 6;
    localparam int SumW         = 11;
    localparam int AccW         = CoefFracBits + 9;
    localparam int MaxHeight    = 4095;
    localparam int MinDim       = 5;

    typedef logic [PixW-1:0] pix_t;

    typedef enum logic {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic [RowW-1:0] row;
        logic [ColW-1:0] col;
        pix_t [4:0][4:0] win;
    } win_item_t;

    // taps grouped by squared distance from the centre
    function automatic int class_of(input int r, input int c);
        int d2;
        begin
            d2 = (r - 2) * (r - 2) + (c - 2) * (c - 2);
            case (d2)
                0:       class_of = 0;
                1:       class_of = 1;
                2:       class_of = 2;
                4:       class_of = 3;
                5:       class_of = 4;
                default: class_of = 5;
            endcase
        end
    endfunction

    function automatic logic [AccW-1:0] class_weight(input int k);
        longint w;
        begin
            case (k)
                0:       w = 10624;
                1:       w = 6444;
                2:       w = 3908;
                3:       w = 1438;
                4:       w = 872;
                default: w = 195;
            endcase
            if (CoefFracBits >= 16)
                w = w << (CoefFracBits - 16);
            else
                w = (((w << 1) >> (16 - CoefFracBits)) + 1) >> 1;
            class_weight = w[AccW-1:0];
        end
    endfunction

endpackage

// ----- rtl/gbr_front.sv -----
// front end: frame counters, line stores and the 5x5 window
`timescale 1ns / 1ps

module gbr_front
    import gbr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    input  cfg_index_t        cfg_index,
    input  logic [RowW-1:0]   cfg_data,
    input  logic              in_valid,
    output logic              in_ready,
    input  pix_t              in_px,
    output logic              win_valid,
    input  logic              win_ready,
    output win_item_t         win_item
);

    logic [WidthW-1:0]   frame_width_reg;
    logic [RowW-1:0]     frame_height_reg;
    logic [ColW-1:0]     col_reg;
    logic [ColW-1:0]     col_next;
    logic [RowW-1:0]     row_reg;
    logic [RowW-1:0]     row_next;
    logic [WidthW:0]     w_sat;
    logic [RowW-1:0]     h_sat;
    logic                accept;

    logic                s1_valid_reg;
    logic [ColW-1:0]     s1_col_reg;
    logic [RowW-1:0]     s1_row_reg;
    logic                s1_int_reg;
    pix_t                s1_px_reg;
    logic                s1_adv;

    logic [4*PixW-1:0]   line_mem [MaxWidth];
    logic [4*PixW-1:0]   rd_reg;

    pix_t [4:0][4:0]     window_reg;
    pix_t [4:0][4:0]     window_next;
    pix_t [4:0]          newcol;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= WidthW'(848);
            frame_height_reg <= RowW'(500);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[WidthW-1:0];
                CFG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                default:          frame_height_reg <= frame_height_reg;
            endcase
        end
    end

    always_comb
    begin
        if ({1'b0, frame_width_reg} < (WidthW+1)'(MinDim))
            w_sat = (WidthW+1)'(MinDim);
        else if ({1'b0, frame_width_reg} > (WidthW+1)'(MaxWidth))
            w_sat = (WidthW+1)'(MaxWidth);
        else
            w_sat = {1'b0, frame_width_reg};
        if (frame_height_reg < RowW'(MinDim))
            h_sat = RowW'(MinDim);
        else if (frame_height_reg > RowW'(MaxHeight))
            h_sat = RowW'(MaxHeight);
        else
            h_sat = frame_height_reg;
    end

    assign s1_adv   = s1_valid_reg && (!s1_int_reg || win_ready);
    assign in_ready = !s1_valid_reg || s1_adv;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        if ((WidthW+1)'(col_reg) + (WidthW+1)'(1) >= w_sat)
        begin
            col_next = '0;
            if ((RowW+1)'(row_reg) + (RowW+1)'(1) >= (RowW+1)'(h_sat))
                row_next = '0;
            else
                row_next = row_reg + RowW'(1);
        end
        else
        begin
            col_next = col_reg + ColW'(1);
            row_next = row_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            if (accept)
                s1_valid_reg <= 1'b1;
            else if (s1_adv)
                s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_col_reg <= col_reg;
            s1_row_reg <= row_reg;
            s1_px_reg  <= in_px;
            s1_int_reg <= (col_reg >= ColW'(4)) && (row_reg >= RowW'(4));
        end
    end

    // line stores: one word per column, four rows side by side, newest lowest
    always_ff @(posedge clk)
    begin
        if (accept)
            rd_reg <= line_mem[col_reg];
        if (s1_adv)
            line_mem[s1_col_reg] <= {rd_reg[3*PixW-1:0], s1_px_reg};
    end

    always_comb
    begin
        newcol[0] = rd_reg[4*PixW-1:3*PixW];
        newcol[1] = rd_reg[3*PixW-1:2*PixW];
        newcol[2] = rd_reg[2*PixW-1:PixW];
        newcol[3] = rd_reg[PixW-1:0];
        newcol[4] = s1_px_reg;
        for (int r = 0; r < 5; r++)
        begin
            for (int c = 0; c < 4; c++)
                window_next[r][c] = window_reg[r][c+1];
            window_next[r][4] = newcol[r];
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
            window_reg <= window_next;
    end

    assign win_valid    = s1_valid_reg && s1_int_reg;
    assign win_item.row = s1_row_reg - RowW'(2);
    assign win_item.col = s1_col_reg - ColW'(2);
    assign win_item.win = window_next;

endmodule

// ----- rtl/gbr_queue.sv -----
// two-entry queue of filled windows between front and back
`timescale 1ns / 1ps

module gbr_queue
    import gbr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  win_item_t in_item,
    output logic      out_valid,
    input  logic      out_ready,
    output win_item_t out_item
);

    win_item_t  slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push;
    logic       pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_item  = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= in_item;
    end

endmodule

// ----- rtl/gbr_back.sv -----
// back end: kernel multiply-accumulate pipeline and output register
`timescale 1ns / 1ps

module gbr_back
    import gbr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  win_item_t         in_item,
    output logic              out_valid,
    input  logic              out_ready,
    output pix_t              out_rgb,
    output logic [RowW-1:0]   out_row,
    output logic [ColW-1:0]   out_col
);

    logic                                a_valid_reg;
    logic                                b_valid_reg;
    logic                                c_valid_reg;
    logic                                a_ready;
    logic                                b_ready;
    logic                                c_ready;

    logic [2:0][NumClass-1:0][SumW-1:0]  a_sum_next;
    logic [2:0][NumClass-1:0][SumW-1:0]  a_sum_reg;
    logic [2:0][NumClass-1:0][AccW-1:0]  b_prod_next;
    logic [2:0][NumClass-1:0][AccW-1:0]  b_prod_reg;
    logic [RowW-1:0]                     a_row_reg;
    logic [RowW-1:0]                     b_row_reg;
    logic [ColW-1:0]                     a_col_reg;
    logic [ColW-1:0]                     b_col_reg;
    logic [2:0][AccW-1:0]                total;
    logic [2:0][AccW-CoefFracBits-1:0]   scaled;
    pix_t                                rgb_next;
    pix_t                                rgb_reg;
    logic [RowW-1:0]                     row_reg;
    logic [ColW-1:0]                     col_reg;

    assign c_ready  = !c_valid_reg || out_ready;
    assign b_ready  = !b_valid_reg || c_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    // sum the taps sharing a weight
    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            for (int k = 0; k < NumClass; k++)
            begin
                a_sum_next[ch][k] = '0;
                for (int r = 0; r < 5; r++)
                    for (int c = 0; c < 5; c++)
                        if (class_of(r, c) == k)
                            a_sum_next[ch][k] = a_sum_next[ch][k]
                                + SumW'(in_item.win[r][c][8*ch +: 8]);
            end
        end
    end

    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
            for (int k = 0; k < NumClass; k++)
                b_prod_next[ch][k] = AccW'(a_sum_reg[ch][k]) * class_weight(k);
    end

    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            total[ch] = '0;
            for (int k = 0; k < NumClass; k++)
                total[ch] = total[ch] + b_prod_reg[ch][k];
            scaled[ch] = total[ch][AccW-1:CoefFracBits];
            if (scaled[ch] > (AccW-CoefFracBits)'(255))
                rgb_next[8*ch +: 8] = 8'hFF;
            else
                rgb_next[8*ch +: 8] = scaled[ch][7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
                a_valid_reg <= in_valid;
            if (b_ready)
                b_valid_reg <= a_valid_reg;
            if (c_ready)
                c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && in_valid)
        begin
            a_sum_reg <= a_sum_next;
            a_row_reg <= in_item.row;
            a_col_reg <= in_item.col;
        end
        if (b_ready && a_valid_reg)
        begin
            b_prod_reg <= b_prod_next;
            b_row_reg  <= a_row_reg;
            b_col_reg  <= a_col_reg;
        end
        if (c_ready && b_valid_reg)
        begin
            rgb_reg <= rgb_next;
            row_reg <= b_row_reg;
            col_reg <= b_col_reg;
        end
    end

    assign out_valid = c_valid_reg;
    assign out_rgb   = rgb_reg;
    assign out_row   = row_reg;
    assign out_col   = col_reg;

endmodule

// ----- rtl/gaussian_blur_5x5_rgb_top.sv -----
// top level of the 5x5 gaussian blur for rgb pixel streams
`timescale 1ns / 1ps

// Pixels enter in raster order on the s_axis channel, one word per pixel.
// A filtered word leaves on m_axis for every pixel two or more away from
// each border of the frame; border pixels give no word. The cfg channel
// writes frame_width (index 0) and frame_height (index 1); it is always
// ready and is to be written only while the block is empty.
// Throughput: one pixel per clock, sustained, while m_axis takes its words.
// A result for a window reaches m_axis once the pixel that completes it
// has passed the line store read, the window queue and the three-stage
// multiply-accumulate pipeline.
// A two-entry window queue and registered stages let the input keep
// flowing while a result waits; when m_axis stalls the stages fill and
// s_axis_tready drops once nothing more can be held.
// Reset clears the counters to row and column zero, restores 848 x 500 and
// empties the pipeline; the line stores are not cleared and fill as the
// first rows of a frame arrive.
module gaussian_blur_5x5_rgb_top
    import gbr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              cfg_index,
    input  logic [11:0]       cfg_data,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [23:0]       s_axis_tdata,   // pixel_rgb
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [47:0]       m_axis_tdata    // blurred_rgb, out_row, out_col, zero pad
);

    logic            fq_valid;
    logic            fq_ready;
    win_item_t       fq_item;
    logic            qb_valid;
    logic            qb_ready;
    win_item_t       qb_item;
    pix_t            out_rgb;
    logic [RowW-1:0] out_row;
    logic [ColW-1:0] out_col;

    assign cfg_ready = 1'b1;

    gbr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index_t'(cfg_index)),
        .cfg_data  (cfg_data),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_px     (s_axis_tdata),
        .win_valid (fq_valid),
        .win_ready (fq_ready),
        .win_item  (fq_item)
    );

    gbr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_item   (fq_item),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_item  (qb_item)
    );

    gbr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (qb_valid),
        .in_ready  (qb_ready),
        .in_item   (qb_item),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_rgb   (out_rgb),
        .out_row   (out_row),
        .out_col   (out_col)
    );

    assign m_axis_tdata = {2'b00, out_col, out_row, out_rgb};

endmodule
